@@ sv/prg_pkg.sv @@
`default_nettype none
package prg_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int VEC_FRAC_DEF   = 14;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_IDX_W      = 3;
	localparam int OUT_BITS       = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_EXTENTS,
		REG_NEAR,
		REG_EYE,
		REG_VIEW,
		REG_RIGHT,
		REG_UP,
		REG_VIEWPORT
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic               inside_res;
		logic signed [15:0] ray_origin_x;
		logic signed [15:0] ray_origin_y;
		logic signed [15:0] ray_origin_z;
		logic signed [15:0] ray_dir_x;
		logic signed [15:0] ray_dir_y;
		logic signed [15:0] ray_dir_z;
	} ray_t;

	typedef struct packed {
		logic               persp;
		logic [63:0]        extents;
		logic signed [15:0] near;
		logic [47:0]        eye;
		logic [47:0]        view;
		logic [47:0]        right;
		logic [47:0]        up;
		logic [63:0]        viewport;
	} cfg_t;

	// classified pixel handed from front to back
	typedef struct packed {
		logic        hit;
		logic [15:0] ox;
		logic [15:0] oy;
	} job_t;

	// sign-extend from bit cb-1 of a field
	function automatic logic signed [24:0] sext_c(logic [47:0] v, int cb);
		logic signed [24:0] r;
		for (int i = 0; i < 25; i++) begin
			r[i] = (i < cb) ? v[i] : v[cb-1];
		end
		return r;
	endfunction

	// saturate to cb bits, keep the low 16
	function automatic logic [15:0] sat_c(logic signed [47:0] v, int cb);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		logic signed [47:0] c;
		hi = (48'sd1 <<< (cb - 1)) - 48'sd1;
		lo = -hi - 48'sd1;
		c  = (v > hi) ? hi : ((v < lo) ? lo : v);
		return c[15:0];
	endfunction

endpackage
`default_nettype wire

@@ sv/pick_ray_generator.sv @@
`default_nettype none
// Pick-ray generator: one screen pixel in, one ray out. A pixel is taken
// when start is high and busy low; one pixel per cycle is sustained. Each
// ray appears on result for exactly one cycle with done high. Its path runs
// through the bit-per-stage viewport dividers, the 31-stage square root and
// the normalizing dividers. The receiver cannot stall; busy rises only if the
// queue between the classifier and the ray pipeline fills. Configuration
// writes are always ready and must be made while no pixel is in flight.
module pick_ray_generator #(
	parameter int COORD_BITS    = prg_pkg::COORD_BITS_DEF,
	parameter int VEC_FRAC_BITS = prg_pkg::VEC_FRAC_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire prg_pkg::pixel_t                pixel,
	output logic                                done,
	output prg_pkg::ray_t                       result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [prg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [63:0]                    cfg_data
);
	import prg_pkg::*;

	cfg_t cfg_q;
	job_t head;
	logic head_valid, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{persp: 1'b1, near: 16'sd256, default: '0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODE:     cfg_q.persp    <= cfg_data[0];
				REG_EXTENTS:  cfg_q.extents  <= cfg_data;
				REG_NEAR:     cfg_q.near     <= cfg_data[15:0];
				REG_EYE:      cfg_q.eye      <= cfg_data[47:0];
				REG_VIEW:     cfg_q.view     <= cfg_data[47:0];
				REG_RIGHT:    cfg_q.right    <= cfg_data[47:0];
				REG_UP:       cfg_q.up       <= cfg_data[47:0];
				REG_VIEWPORT: cfg_q.viewport <= cfg_data;
				default: ;
			endcase
		end
	end

	prg_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.pixel      (pixel),
		.cfg        (cfg_q),
		.pop        (pop),
		.busy       (busy),
		.head       (head),
		.head_valid (head_valid)
	);

	prg_back #(.COORD_BITS(COORD_BITS), .VEC_FRAC_BITS(VEC_FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head),
		.job_valid (head_valid),
		.cfg       (cfg_q),
		.pop       (pop),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire

@@ sv/prg_div.sv @@
`default_nettype none
module prg_div #(
	parameter int NW = 34,
	parameter int DW = 16,
	parameter int QW = 17,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [QW-1:0]      quo,
	output logic [SW-1:0]      side_out
);
	// one quotient bit per stage; quotient known to fit QW bits

	logic [NW-1:0] top;
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [QW-1:0] low_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];
	logic          vld_s  [QW];

	logic [DW-1:0] rem_n  [QW];
	logic [QW-1:0] quo_n  [QW];
	logic [QW-1:0] low_n  [QW];
	logic [DW-1:0] den_n  [QW];
	logic [SW-1:0] side_n [QW];
	logic          vld_n  [QW];

	assign top = num >> QW;

	always_comb begin
		logic [DW-1:0] r;
		logic [QW-1:0] q;
		logic [QW-1:0] l;
		logic [DW:0]   t;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				r         = top[DW-1:0];
				q         = '0;
				l         = num[QW-1:0];
				den_n[k]  = den;
				side_n[k] = side_in;
				vld_n[k]  = in_valid;
			end else begin
				r         = rem_s[k-1];
				q         = quo_s[k-1];
				l         = low_s[k-1];
				den_n[k]  = den_s[k-1];
				side_n[k] = side_s[k-1];
				vld_n[k]  = vld_s[k-1];
			end
			t = {r, l[QW-1]};
			if (t >= {1'b0, den_n[k]}) begin
				rem_n[k] = DW'(t - {1'b0, den_n[k]});
				quo_n[k] = {q[QW-2:0], 1'b1};
			end else begin
				rem_n[k] = t[DW-1:0];
				quo_n[k] = {q[QW-2:0], 1'b0};
			end
			low_n[k] = {l[QW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) vld_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < QW; k++) vld_s[k] <= vld_n[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QW; k++) begin
			rem_s[k]  <= rem_n[k];
			quo_s[k]  <= quo_n[k];
			low_s[k]  <= low_n[k];
			den_s[k]  <= den_n[k];
			side_s[k] <= side_n[k];
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule
`default_nettype wire

@@ sv/prg_sqrt.sv @@
`default_nettype none
module prg_sqrt #(
	parameter int IW = 62,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [IW-1:0] rad,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [IW/2-1:0]    root,
	output logic [SW-1:0]      side_out
);
	// floor square root, one root bit per stage
	localparam int RTW = IW / 2;
	localparam int RW  = RTW + 2;

	logic [RW-1:0]  rem_s  [RTW];
	logic [RTW-1:0] root_s [RTW];
	logic [IW-1:0]  rad_s  [RTW];
	logic [SW-1:0]  side_s [RTW];
	logic           vld_s  [RTW];

	logic [RW-1:0]  rem_n  [RTW];
	logic [RTW-1:0] root_n [RTW];
	logic [IW-1:0]  rad_n  [RTW];
	logic [SW-1:0]  side_n [RTW];
	logic           vld_n  [RTW];

	always_comb begin
		logic [RW-1:0]  r;
		logic [RTW-1:0] q;
		logic [IW-1:0]  a;
		logic [RW+1:0]  t;
		logic [RW+1:0]  trial;
		for (int k = 0; k < RTW; k++) begin
			if (k == 0) begin
				r         = '0;
				q         = '0;
				a         = rad;
				side_n[k] = side_in;
				vld_n[k]  = in_valid;
			end else begin
				r         = rem_s[k-1];
				q         = root_s[k-1];
				a         = rad_s[k-1];
				side_n[k] = side_s[k-1];
				vld_n[k]  = vld_s[k-1];
			end
			t     = {r, a[IW-1:IW-2]};
			trial = {2'b00, q, 2'b01};
			if (t >= trial) begin
				rem_n[k]  = RW'(t - trial);
				root_n[k] = {q[RTW-2:0], 1'b1};
			end else begin
				rem_n[k]  = t[RW-1:0];
				root_n[k] = {q[RTW-2:0], 1'b0};
			end
			rad_n[k] = {a[IW-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RTW; k++) vld_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < RTW; k++) vld_s[k] <= vld_n[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < RTW; k++) begin
			rem_s[k]  <= rem_n[k];
			root_s[k] <= root_n[k];
			rad_s[k]  <= rad_n[k];
			side_s[k] <= side_n[k];
		end
	end

	assign out_valid = vld_s[RTW-1];
	assign root      = root_s[RTW-1];
	assign side_out  = side_s[RTW-1];

endmodule
`default_nettype wire

@@ sv/prg_front.sv @@
`default_nettype none
module prg_front #(
	parameter int COORD_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire prg_pkg::pixel_t pixel,
	input  wire prg_pkg::cfg_t   cfg,
	input  wire logic            pop,
	output logic                 busy,
	output prg_pkg::job_t        head,
	output logic                 head_valid
);
	import prg_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic signed [25:0] px, py, vx, vy, vw, vh, dx, dy;
	logic               hit;

	logic               v_s1;
	job_t               job_s1;

	job_t               mem_q [QUEUE_DEPTH];
	logic [AW-1:0]      wr_q, rd_q;
	logic [CW-1:0]      cnt_q;
	logic               push, take;

	always_comb begin
		px  = 26'(sext_c({32'b0, pixel.pixel_x}, COORD_BITS));
		py  = 26'(sext_c({32'b0, pixel.pixel_y}, COORD_BITS));
		vx  = 26'(sext_c(cfg.viewport[47:0], COORD_BITS));
		vy  = 26'(sext_c(cfg.viewport[63:16], COORD_BITS));
		vw  = $signed({10'b0, cfg.viewport[47:32]});
		vh  = $signed({10'b0, cfg.viewport[63:48]});
		dx  = px - vx;
		dy  = py - vy;
		hit = (vw != 26'sd0) && (vh != 26'sd0) && (dx >= 26'sd0) && (dx <= vw) &&
		      (dy >= 26'sd0) && (dy <= vh);
	end

	assign busy = ({1'b0, cnt_q} + {{CW{1'b0}}, v_s1}) >= (CW+1)'(QUEUE_DEPTH);
	assign push = v_s1;
	assign take = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			v_s1 <= start && !busy;
			if (push) wr_q <= wr_q + 1'b1;
			if (take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(push) - CW'(take);
		end
	end

	always_ff @(posedge clk) begin
		job_s1.hit <= hit;
		job_s1.ox  <= dx[15:0];
		job_s1.oy  <= dy[15:0];
		if (push) mem_q[wr_q] <= job_s1;
	end

	assign head       = mem_q[rd_q];
	assign head_valid = cnt_q != '0;

endmodule
`default_nettype wire

@@ sv/prg_back.sv @@
`default_nettype none
module prg_back #(
	parameter int COORD_BITS    = 16,
	parameter int VEC_FRAC_BITS = 14
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire prg_pkg::job_t job,
	input  wire logic          job_valid,
	input  wire prg_pkg::cfg_t cfg,
	output logic               pop,
	output logic               done,
	output prg_pkg::ray_t      result
);
	import prg_pkg::*;

	localparam int F    = VEC_FRAC_BITS;
	localparam int BNW  = 34;
	localparam int BQW  = 17;
	localparam int SQIW = 62;
	localparam int NNW  = 31 + F;
	localparam int NQW  = F + 1;

	typedef struct packed {
		logic        hit;
		logic [2:0]  neg;
		logic [47:0] org;
	} tail_t;

	typedef struct packed {
		tail_t       t;
		logic        zero;
		logic [89:0] m;
	} sq_side_t;

	typedef struct packed {
		logic        hit;
		logic        zero;
		logic        neg0;
		logic [47:0] org;
	} dv_side_t;

	logic signed [15:0] rmin, rmax, umin, umax;
	logic signed [16:0] dr, du;
	logic signed [16:0] oxs, oys;

	assign rmin = cfg.extents[15:0];
	assign rmax = cfg.extents[31:16];
	assign umin = cfg.extents[47:32];
	assign umax = cfg.extents[63:48];
	assign dr   = {rmax[15], rmax} - {rmin[15], rmin};
	assign du   = {umax[15], umax} - {umin[15], umin};
	assign oxs  = $signed({1'b0, job.ox});
	assign oys  = $signed({1'b0, job.oy});
	assign pop  = job_valid;

	// blend numerators
	logic               v_s1, hit_s1;
	logic signed [33:0] pr_s1, pu_s1;

	logic               v_s2, hit_s2, negr_s2, negu_s2;
	logic [BNW-1:0]     nr_s2, nu_s2;

	logic               dvr, dvu;
	logic [BQW-1:0]     qr, qu;
	logic [1:0]         sdr;
	logic               sdu;

	logic               v_s3, hit_s3;
	logic signed [18:0] rb_s3, ub_s3;

	logic               v_s4, hit_s4;
	logic signed [47:0] pa_s4 [3];
	logic signed [47:0] pr_s4 [3];
	logic signed [47:0] pu_s4 [3];

	logic               v_s5, hit_s5;
	logic signed [47:0] sum_s5 [3];

	logic               v_s6;
	tail_t              t_s6;
	logic [47:0]        mag_s6 [3];

	logic               v_s7;
	tail_t              t_s7;
	logic [47:0]        mag_s7 [3];
	logic [47:0]        max_s7;

	logic               v_s8;
	tail_t              t_s8;
	logic [47:0]        mag_s8 [3];
	logic [5:0]         nz_s8;
	logic [2:0]         pos_s8 [6];

	logic               v_s9, rsh_s9, zero_s9;
	tail_t              t_s9;
	logic [47:0]        mag_s9 [3];
	logic [5:0]         amt_s9;

	logic               v_s10, zero_s10;
	tail_t              t_s10;
	logic [29:0]        m_s10 [3];

	logic               v_s11, zero_s11;
	tail_t              t_s11;
	logic [29:0]        m_s11 [3];
	logic [59:0]        sq_s11 [3];

	logic               v_s12;
	sq_side_t           sd_s12;
	logic [SQIW-1:0]    sos_s12;

	logic               sq_v;
	logic [SQIW/2-1:0]  len;
	sq_side_t           sq_sd;

	logic               v_s13;
	dv_side_t           dsd_s13;
	logic [2:0]         neg_s13;
	logic [NNW-1:0]     num_s13 [3];
	logic [30:0]        len_s13;

	logic               nv;
	logic [NQW-1:0]     nq [3];
	dv_side_t           nsd;
	logic               nneg1, nneg2;

	logic               done_q;
	ray_t               res_q;

	// s1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1  <= job_valid;
			v_s2  <= v_s1;
			v_s3  <= dvr;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= sq_v;
			done_q <= nv;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1 <= job.hit;
		pr_s1  <= dr * oxs;
		pu_s1  <= du * oys;
	end

	// s2: magnitude plus half divisor
	always_ff @(posedge clk) begin
		hit_s2  <= hit_s1;
		negr_s2 <= pr_s1 < 34'sd0;
		negu_s2 <= pu_s1 < 34'sd0;
		nr_s2   <= ((pr_s1 < 34'sd0) ? BNW'(-pr_s1) : BNW'(pr_s1)) +
		           BNW'(cfg.viewport[47:33]);
		nu_s2   <= ((pu_s1 < 34'sd0) ? BNW'(-pu_s1) : BNW'(pu_s1)) +
		           BNW'(cfg.viewport[63:49]);
	end

	prg_div #(.NW(BNW), .DW(16), .QW(BQW), .SW(2)) u_div_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.num       (nr_s2),
		.den       (cfg.viewport[47:32]),
		.side_in   ({hit_s2, negr_s2}),
		.out_valid (dvr),
		.quo       (qr),
		.side_out  (sdr)
	);

	prg_div #(.NW(BNW), .DW(16), .QW(BQW), .SW(1)) u_div_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.num       (nu_s2),
		.den       (cfg.viewport[63:48]),
		.side_in   (negu_s2),
		.out_valid (dvu),
		.quo       (qu),
		.side_out  (sdu)
	);

	// s3: blended extents
	always_ff @(posedge clk) begin
		logic signed [18:0] qrs, qus;
		qrs = $signed({2'b00, qr});
		qus = $signed({2'b00, qu});
		hit_s3 <= sdr[1] && dvu;
		rb_s3  <= {{3{rmin[15]}}, rmin} + (sdr[0] ? -qrs : qrs);
		ub_s3  <= {{3{umin[15]}}, umin} + (sdu ? -qus : qus);
	end

	// s4: per-axis products
	always_ff @(posedge clk) begin
		logic signed [15:0] dc, rc, uc, ec;
		hit_s4 <= hit_s3;
		for (int i = 0; i < 3; i++) begin
			dc = cfg.view[16*i +: 16];
			rc = cfg.right[16*i +: 16];
			uc = cfg.up[16*i +: 16];
			ec = cfg.eye[16*i +: 16];
			pa_s4[i] <= cfg.persp ? 48'(cfg.near * dc) : (48'(ec) <<< F);
			pr_s4[i] <= rb_s3 * rc;
			pu_s4[i] <= ub_s3 * uc;
		end
	end

	// s5: sums
	always_ff @(posedge clk) begin
		hit_s5 <= hit_s4;
		for (int i = 0; i < 3; i++) sum_s5[i] <= pa_s4[i] + pr_s4[i] + pu_s4[i];
	end

	// s6: origin, magnitudes
	always_ff @(posedge clk) begin
		logic signed [47:0] half, rq;
		logic signed [15:0] ec;
		half = 48'sd1 <<< (F - 1);
		t_s6.hit <= hit_s5;
		for (int i = 0; i < 3; i++) begin
			ec = cfg.eye[16*i +: 16];
			if (sum_s5[i] >= 48'sd0) rq = (sum_s5[i] + half) >>> F;
			else rq = -((-sum_s5[i] + half) >>> F);
			t_s6.org[16*i +: 16] <= cfg.persp ? sat_c(48'(ec), COORD_BITS) :
			                        sat_c(rq, COORD_BITS);
			t_s6.neg[i] <= sum_s5[i] < 48'sd0;
			mag_s6[i]   <= (sum_s5[i] < 48'sd0) ? 48'(-sum_s5[i]) : 48'(sum_s5[i]);
		end
	end

	// s7: largest magnitude
	always_ff @(posedge clk) begin
		logic [47:0] m;
		m = (mag_s6[0] > mag_s6[1]) ? mag_s6[0] : mag_s6[1];
		t_s7   <= t_s6;
		mag_s7 <= mag_s6;
		max_s7 <= (mag_s6[2] > m) ? mag_s6[2] : m;
	end

	// s8: leading one per byte
	always_ff @(posedge clk) begin
		logic [2:0] p;
		t_s8   <= t_s7;
		mag_s8 <= mag_s7;
		for (int g = 0; g < 6; g++) begin
			p = '0;
			for (int j = 0; j < 8; j++) if (max_s7[8*g+j]) p = 3'(j);
			nz_s8[g]  <= |max_s7[8*g +: 8];
			pos_s8[g] <= p;
		end
	end

	// s9: shift amount to put the leading one at bit 29
	always_ff @(posedge clk) begin
		logic [5:0] p;
		p = '0;
		for (int g = 0; g < 6; g++) if (nz_s8[g]) p = {3'(g), pos_s8[g]};
		t_s9    <= t_s8;
		mag_s9  <= mag_s8;
		zero_s9 <= nz_s8 == '0;
		rsh_s9  <= p > 6'd29;
		amt_s9  <= (p > 6'd29) ? p - 6'd29 : 6'd29 - p;
	end

	// s10: scale
	always_ff @(posedge clk) begin
		logic [47:0] sh;
		t_s10    <= t_s9;
		zero_s10 <= zero_s9;
		for (int i = 0; i < 3; i++) begin
			sh = rsh_s9 ? (mag_s9[i] >> amt_s9) : (mag_s9[i] << amt_s9);
			m_s10[i] <= sh[29:0];
		end
	end

	// s11: squares
	always_ff @(posedge clk) begin
		t_s11    <= t_s10;
		zero_s11 <= zero_s10;
		m_s11    <= m_s10;
		for (int i = 0; i < 3; i++) sq_s11[i] <= m_s10[i] * m_s10[i];
	end

	// s12: sum of squares
	always_ff @(posedge clk) begin
		sd_s12.t    <= t_s11;
		sd_s12.zero <= zero_s11;
		sd_s12.m    <= {m_s11[2], m_s11[1], m_s11[0]};
		sos_s12     <= SQIW'(sq_s11[0]) + SQIW'(sq_s11[1]) + SQIW'(sq_s11[2]);
	end

	prg_sqrt #(.IW(SQIW), .SW($bits(sq_side_t))) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s12),
		.rad       (sos_s12),
		.side_in   (sd_s12),
		.out_valid (sq_v),
		.root      (len),
		.side_out  (sq_sd)
	);

	// s13: rounded quotient numerators
	always_ff @(posedge clk) begin
		dsd_s13.hit  <= sq_sd.t.hit;
		dsd_s13.zero <= sq_sd.zero;
		dsd_s13.neg0 <= sq_sd.t.neg[0];
		dsd_s13.org  <= sq_sd.t.org;
		neg_s13      <= sq_sd.t.neg;
		len_s13      <= len;
		for (int i = 0; i < 3; i++) begin
			num_s13[i] <= (NNW'(sq_sd.m[30*i +: 30]) << F) + NNW'(len[30:1]);
		end
	end

	prg_div #(.NW(NNW), .DW(31), .QW(NQW), .SW($bits(dv_side_t))) u_div_n0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s13),
		.num       (num_s13[0]),
		.den       (len_s13),
		.side_in   (dsd_s13),
		.out_valid (nv),
		.quo       (nq[0]),
		.side_out  (nsd)
	);

	prg_div #(.NW(NNW), .DW(31), .QW(NQW), .SW(1)) u_div_n1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s13),
		.num       (num_s13[1]),
		.den       (len_s13),
		.side_in   (neg_s13[1]),
		.out_valid (),
		.quo       (nq[1]),
		.side_out  (nneg1)
	);

	prg_div #(.NW(NNW), .DW(31), .QW(NQW), .SW(1)) u_div_n2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s13),
		.num       (num_s13[2]),
		.den       (len_s13),
		.side_in   (neg_s13[2]),
		.out_valid (),
		.quo       (nq[2]),
		.side_out  (nneg2)
	);

	// output word
	always_ff @(posedge clk) begin
		logic [2:0]  ng;
		logic [15:0] d [3];
		ng = {nneg2, nneg1, nsd.neg0};
		for (int i = 0; i < 3; i++) begin
			if (!cfg.persp) d[i] = cfg.view[16*i +: 16];
			else if (nsd.zero) d[i] = '0;
			else if (ng[i]) d[i] = sat_c(-$signed(48'(nq[i])), OUT_BITS);
			else d[i] = sat_c($signed(48'(nq[i])), OUT_BITS);
		end
		if (nsd.hit) begin
			res_q.inside_res   <= 1'b1;
			res_q.ray_origin_x <= nsd.org[15:0];
			res_q.ray_origin_y <= nsd.org[31:16];
			res_q.ray_origin_z <= nsd.org[47:32];
			res_q.ray_dir_x    <= d[0];
			res_q.ray_dir_y    <= d[1];
			res_q.ray_dir_z    <= d[2];
		end else begin
			res_q <= '0;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire
